// ----- src/lavm_pkg.sv -----
// Shared constants of the look-at view matrix datapath.
`timescale 1ns / 1ps

package lavm_pkg;

  localparam int COORD_W = 32;
  localparam int AXIS_W = 18;
  localparam int NORM_W = 30;
  localparam int STAGE_STEPS = 4;

endpackage

// ----- src/lavm_norm.sv -----
// Pipelined normalizer that turns a signed 3-vector into its unit vector.
`timescale 1ns / 1ps

module lavm_norm #(
  parameter int IN_W = 33,
  parameter int FB = 16,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [IN_W-1:0]  vec_i [3],
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic signed [FB+1:0]    unit_o [3],
  output logic [SIDE_W-1:0]       side_o
);
  import lavm_pkg::*;

  localparam int SHW = $clog2(IN_W + NORM_W);
  localparam int EXT_W = IN_W + NORM_W;
  localparam int SUM_W = 2 * NORM_W + 2;
  localparam int ROOT_W = NORM_W + 1;
  localparam int REM_W = ROOT_W + 5;
  localparam int NSQ = (ROOT_W + STAGE_STEPS - 1) / STAGE_STEPS;
  localparam int QW = FB + 1;
  localparam int NUM_W = NORM_W + FB + 2;
  localparam int DEN_W = ROOT_W + 1;
  localparam int DREM_W = DEN_W + 1;
  localparam int NDV = (QW + STAGE_STEPS - 1) / STAGE_STEPS;

  typedef struct packed {
    logic              zero;
    logic [2:0]        neg;
    logic [SIDE_W-1:0] side;
  } tag_t;

  logic              va_q, vb_q, vc_q, vd_q, ve_q;
  tag_t              ta_q, tb_q, tc_q, td_q, te_q;
  logic [IN_W-1:0]   ma_q [3];
  logic [IN_W-1:0]   mb_q [3];
  logic [IN_W-1:0]   mc_q [3];
  logic [IN_W-1:0]   top_b_q;
  logic              rc_q;
  logic [SHW-1:0]    ac_q;
  logic [NORM_W-1:0] md_q [3];
  logic [NORM_W-1:0] me_q [3];
  logic [2*NORM_W-1:0] sqe_q [3];

  logic [SHW-1:0]    pos_d;
  logic              right_d;
  logic [SHW-1:0]    amt_d;

  logic              sq_v_q [NSQ+1];
  tag_t              sq_t_q [NSQ+1];
  logic [NORM_W-1:0] sq_m_q [NSQ+1][3];
  logic [SUM_W-1:0]  sq_s_q [NSQ+1];
  logic [REM_W-1:0]  sq_rem_q [NSQ+1];
  logic [ROOT_W-1:0] sq_root_q [NSQ+1];

  logic              dv_v_q [NDV+1];
  tag_t              dv_t_q [NDV+1];
  logic [DEN_W-1:0]  dv_den_q [NDV+1];
  logic [DREM_W-1:0] dv_rem_q [NDV+1][3];
  logic [QW-1:0]     dv_nb_q [NDV+1][3];
  logic [QW-1:0]     dv_quo_q [NDV+1][3];

  logic              vo_q;
  logic [SIDE_W-1:0] side_q;
  logic signed [FB+1:0] unit_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      sq_v_q[0] <= 1'b0;
      dv_v_q[0] <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      sq_v_q[0] <= ve_q;
      dv_v_q[0] <= sq_v_q[NSQ];
      vo_q <= dv_v_q[NDV];
    end
  end

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (top_b_q[i]) begin
        pos_d = SHW'(i);
      end
    end
    right_d = pos_d > SHW'(NORM_W - 1);
    amt_d = right_d ? pos_d - SHW'(NORM_W - 1) : SHW'(NORM_W - 1) - pos_d;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ma_q[k] <= vec_i[k][IN_W-1] ? $unsigned(-vec_i[k]) : $unsigned(vec_i[k]);
      ta_q.neg[k] <= vec_i[k][IN_W-1];
    end
    ta_q.side <= side_i;
    ta_q.zero <= 1'b0;

    mb_q <= ma_q;
    tb_q <= ta_q;
    top_b_q <= (ma_q[0] > ma_q[1]) ?
               ((ma_q[0] > ma_q[2]) ? ma_q[0] : ma_q[2]) :
               ((ma_q[1] > ma_q[2]) ? ma_q[1] : ma_q[2]);

    mc_q <= mb_q;
    tc_q.neg <= tb_q.neg;
    tc_q.side <= tb_q.side;
    tc_q.zero <= top_b_q == '0;
    rc_q <= right_d;
    ac_q <= amt_d;

    for (int k = 0; k < 3; k++) begin
      md_q[k] <= rc_q ? NORM_W'(EXT_W'(mc_q[k]) >> ac_q) : NORM_W'(EXT_W'(mc_q[k]) << ac_q);
    end
    td_q <= tc_q;

    for (int k = 0; k < 3; k++) begin
      sqe_q[k] <= md_q[k] * md_q[k];
    end
    me_q <= md_q;
    te_q <= td_q;

    sq_s_q[0] <= SUM_W'(sqe_q[0]) + SUM_W'(sqe_q[1]) + SUM_W'(sqe_q[2]);
    sq_rem_q[0] <= '0;
    sq_root_q[0] <= '0;
    sq_m_q[0] <= me_q;
    sq_t_q[0] <= te_q;
  end

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    logic [REM_W-1:0]  rem_n;
    logic [ROOT_W-1:0] root_n;
    logic [SUM_W-1:0]  s_n;

    always_comb begin
      logic [REM_W-1:0] trial;
      trial = '0;
      rem_n = sq_rem_q[g];
      root_n = sq_root_q[g];
      s_n = sq_s_q[g];
      for (int j = 0; j < STAGE_STEPS; j++) begin
        if (g * STAGE_STEPS + j < ROOT_W) begin
          rem_n = {rem_n[REM_W-3:0], s_n[SUM_W-1:SUM_W-2]};
          s_n = {s_n[SUM_W-3:0], 2'b00};
          trial = REM_W'({root_n, 2'b01});
          if (rem_n >= trial) begin
            rem_n = rem_n - trial;
            root_n = {root_n[ROOT_W-2:0], 1'b1};
          end else begin
            root_n = {root_n[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[g+1] <= 1'b0;
      end else begin
        sq_v_q[g+1] <= sq_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[g+1] <= rem_n;
      sq_root_q[g+1] <= root_n;
      sq_s_q[g+1] <= s_n;
      sq_m_q[g+1] <= sq_m_q[g];
      sq_t_q[g+1] <= sq_t_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NUM_W-1:0] num;
    for (int k = 0; k < 3; k++) begin
      num = (NUM_W'(sq_m_q[NSQ][k]) << (FB + 1)) + NUM_W'(sq_root_q[NSQ]);
      dv_rem_q[0][k] <= DREM_W'(num >> QW);
      dv_nb_q[0][k] <= num[QW-1:0];
      dv_quo_q[0][k] <= '0;
    end
    dv_den_q[0] <= {sq_root_q[NSQ], 1'b0};
    dv_t_q[0] <= sq_t_q[NSQ];
  end

  for (genvar g = 0; g < NDV; g++) begin : g_div
    logic [DREM_W-1:0] rem_n [3];
    logic [QW-1:0]     nb_n [3];
    logic [QW-1:0]     quo_n [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_n[k] = dv_rem_q[g][k];
        nb_n[k] = dv_nb_q[g][k];
        quo_n[k] = dv_quo_q[g][k];
        for (int j = 0; j < STAGE_STEPS; j++) begin
          if (g * STAGE_STEPS + j < QW) begin
            rem_n[k] = {rem_n[k][DREM_W-2:0], nb_n[k][QW-1]};
            nb_n[k] = {nb_n[k][QW-2:0], 1'b0};
            if (rem_n[k] >= DREM_W'(dv_den_q[g])) begin
              rem_n[k] = rem_n[k] - DREM_W'(dv_den_q[g]);
              quo_n[k] = {quo_n[k][QW-2:0], 1'b1};
            end else begin
              quo_n[k] = {quo_n[k][QW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[g+1] <= 1'b0;
      end else begin
        dv_v_q[g+1] <= dv_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[g+1] <= rem_n;
      dv_nb_q[g+1] <= nb_n;
      dv_quo_q[g+1] <= quo_n;
      dv_den_q[g+1] <= dv_den_q[g];
      dv_t_q[g+1] <= dv_t_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [FB+1:0] qs;
    for (int k = 0; k < 3; k++) begin
      qs = $signed((FB + 2)'(dv_quo_q[NDV][k]));
      if (dv_t_q[NDV].zero) begin
        unit_q[k] <= '0;
      end else if (dv_t_q[NDV].neg[k]) begin
        unit_q[k] <= -qs;
      end else begin
        unit_q[k] <= qs;
      end
    end
    side_q <= dv_t_q[NDV].side;
  end

  assign valid_o = vo_q;
  assign unit_o = unit_q;
  assign side_o = side_q;

endmodule

// ----- src/look_at_view_matrix_top.sv -----
// Top level of the look-at view matrix pipeline.
`timescale 1ns / 1ps

// Usage: drive eye_*_i and target_*_i (signed, FRAC_BITS fraction bits) and
// raise start for one cycle per beat. The block is fully pipelined, so busy
// stays low and a new beat can enter in every cycle.
// Each beat yields one result beat, shown on the result ports for exactly one
// cycle while valid_o is high. The receiver cannot hold results off, and none
// is needed: results leave in the order the beats entered.
// The pipeline is three chained normalizers, each with an eight-stage square
// root and a division that retires four quotient bits per stage, plus the
// difference, cross product and dot product stages.
// Throughput is one beat per cycle.
// Reset clears every valid bit in the pipeline, so no result beat comes out
// until a beat has been accepted after reset; data registers are not cleared.
module look_at_view_matrix_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lavm_pkg::COORD_W-1:0] eye_x_i,
  input  logic signed [lavm_pkg::COORD_W-1:0] eye_y_i,
  input  logic signed [lavm_pkg::COORD_W-1:0] eye_z_i,
  input  logic signed [lavm_pkg::COORD_W-1:0] target_x_i,
  input  logic signed [lavm_pkg::COORD_W-1:0] target_y_i,
  input  logic signed [lavm_pkg::COORD_W-1:0] target_z_i,
  output logic                                valid_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  right_x_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  right_y_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  right_z_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  upward_x_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  upward_y_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  upward_z_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  forward_x_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  forward_y_o,
  output logic signed [lavm_pkg::AXIS_W-1:0]  forward_z_o,
  output logic signed [lavm_pkg::COORD_W-1:0] shift_right_o,
  output logic signed [lavm_pkg::COORD_W-1:0] shift_up_o,
  output logic signed [lavm_pkg::COORD_W-1:0] shift_forward_o
);
  import lavm_pkg::*;

  localparam int UW = FRAC_BITS + 2;
  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * UW;
  localparam int XW = 2 * FRAC_BITS + 3;
  localparam int DPW = UW + COORD_W;
  localparam int DSW = DPW + 2;
  localparam int EYE_W = 3 * COORD_W;
  localparam int SIDE2_W = 3 * UW + EYE_W;
  localparam int SIDE3_W = 3 * UW + SIDE2_W;
  localparam logic [DSW-1:0] POS_LIM = DSW'(64'h7fffffff);
  localparam logic [DSW-1:0] NEG_LIM = DSW'(64'h80000000);

  logic                    v1_q;
  logic signed [COORD_W-1:0] eye1_q [3];
  logic signed [DW-1:0]    d1_q [3];

  logic                    n1_valid;
  logic signed [UW-1:0]    fw1 [3];
  logic [EYE_W-1:0]        n1_side;

  logic signed [UW-1:0]    vec2 [3];
  logic                    n2_valid;
  logic signed [UW-1:0]    rt2 [3];
  logic [SIDE2_W-1:0]      n2_side;
  logic signed [UW-1:0]    fw2 [3];

  logic                    x1_v_q, x2_v_q;
  logic signed [PW-1:0]    p_q [6];
  logic [SIDE3_W-1:0]      x1_side_q, x2_side_q;
  logic signed [XW-1:0]    c_q [3];

  logic                    n3_valid;
  logic signed [UW-1:0]    up3 [3];
  logic [SIDE3_W-1:0]      n3_side;
  logic signed [UW-1:0]    ax3 [9];
  logic signed [COORD_W-1:0] eye3 [3];

  logic                    d1_v_q, d2_v_q, out_v_q;
  logic signed [DPW-1:0]   dp_q [9];
  logic signed [UW-1:0]    ax_d1_q [9];
  logic signed [UW-1:0]    ax_d2_q [9];
  logic signed [DSW-1:0]   nd_q [3];
  logic signed [UW-1:0]    ax_o_q [9];
  logic signed [COORD_W-1:0] sh_o_q [3];
  logic signed [COORD_W-1:0] sh_d [3];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      x1_v_q <= 1'b0;
      x2_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      x1_v_q <= n2_valid;
      x2_v_q <= x1_v_q;
      d1_v_q <= n3_valid;
      d2_v_q <= d1_v_q;
      out_v_q <= d2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eye1_q[0] <= eye_x_i;
    eye1_q[1] <= eye_y_i;
    eye1_q[2] <= eye_z_i;
    d1_q[0] <= DW'(target_x_i) - DW'(eye_x_i);
    d1_q[1] <= DW'(target_y_i) - DW'(eye_y_i);
    d1_q[2] <= DW'(target_z_i) - DW'(eye_z_i);
  end

  lavm_norm #(
    .IN_W   (DW),
    .FB     (FRAC_BITS),
    .SIDE_W (EYE_W)
  ) u_norm_fw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .vec_i   (d1_q),
    .side_i  ({eye1_q[2], eye1_q[1], eye1_q[0]}),
    .valid_o (n1_valid),
    .unit_o  (fw1),
    .side_o  (n1_side)
  );

  assign vec2[0] = fw1[2];
  assign vec2[1] = '0;
  assign vec2[2] = -fw1[0];

  lavm_norm #(
    .IN_W   (UW),
    .FB     (FRAC_BITS),
    .SIDE_W (SIDE2_W)
  ) u_norm_rt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n1_valid),
    .vec_i   (vec2),
    .side_i  ({fw1[2], fw1[1], fw1[0], n1_side}),
    .valid_o (n2_valid),
    .unit_o  (rt2),
    .side_o  (n2_side)
  );

  for (genvar k = 0; k < 3; k++) begin : g_fw2
    assign fw2[k] = n2_side[EYE_W + k * UW +: UW];
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= fw2[1] * rt2[2];
    p_q[1] <= fw2[2] * rt2[1];
    p_q[2] <= fw2[2] * rt2[0];
    p_q[3] <= fw2[0] * rt2[2];
    p_q[4] <= fw2[0] * rt2[1];
    p_q[5] <= fw2[1] * rt2[0];
    x1_side_q <= {rt2[2], rt2[1], rt2[0], n2_side};
    c_q[0] <= XW'(p_q[0] - p_q[1]);
    c_q[1] <= XW'(p_q[2] - p_q[3]);
    c_q[2] <= XW'(p_q[4] - p_q[5]);
    x2_side_q <= x1_side_q;
  end

  lavm_norm #(
    .IN_W   (XW),
    .FB     (FRAC_BITS),
    .SIDE_W (SIDE3_W)
  ) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x2_v_q),
    .vec_i   (c_q),
    .side_i  (x2_side_q),
    .valid_o (n3_valid),
    .unit_o  (up3),
    .side_o  (n3_side)
  );

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign eye3[k] = n3_side[k * COORD_W +: COORD_W];
    assign ax3[k] = n3_side[SIDE2_W + k * UW +: UW];
    assign ax3[3 + k] = up3[k];
    assign ax3[6 + k] = n3_side[EYE_W + k * UW +: UW];
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        dp_q[3 * r + k] <= ax3[3 * r + k] * eye3[k];
      end
      nd_q[r] <= -(DSW'(dp_q[3 * r]) + DSW'(dp_q[3 * r + 1]) + DSW'(dp_q[3 * r + 2]));
    end
    ax_d1_q <= ax3;
    ax_d2_q <= ax_d1_q;
    ax_o_q <= ax_d2_q;
    sh_o_q <= sh_d;
  end

  always_comb begin
    logic [DSW-1:0] mag;
    logic [DSW-1:0] rnd;
    mag = '0;
    rnd = '0;
    for (int r = 0; r < 3; r++) begin
      mag = nd_q[r][DSW-1] ? $unsigned(-nd_q[r]) : $unsigned(nd_q[r]);
      rnd = (mag + (DSW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (nd_q[r][DSW-1]) begin
        sh_d[r] = (rnd > NEG_LIM) ? COORD_W'(NEG_LIM) : COORD_W'(DSW'(0) - rnd);
      end else begin
        sh_d[r] = (rnd > POS_LIM) ? COORD_W'(POS_LIM) : COORD_W'(rnd);
      end
    end
  end

  assign valid_o = out_v_q;
  assign right_x_o = AXIS_W'(ax_o_q[0]);
  assign right_y_o = AXIS_W'(ax_o_q[1]);
  assign right_z_o = AXIS_W'(ax_o_q[2]);
  assign upward_x_o = AXIS_W'(ax_o_q[3]);
  assign upward_y_o = AXIS_W'(ax_o_q[4]);
  assign upward_z_o = AXIS_W'(ax_o_q[5]);
  assign forward_x_o = AXIS_W'(ax_o_q[6]);
  assign forward_y_o = AXIS_W'(ax_o_q[7]);
  assign forward_z_o = AXIS_W'(ax_o_q[8]);
  assign shift_right_o = sh_o_q[0];
  assign shift_up_o = sh_o_q[1];
  assign shift_forward_o = sh_o_q[2];

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the look-at view matrix pipeline.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = 16;
  localparam int LATENCY = 69;

  typedef struct packed {
    logic [17:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
    logic [31:0] sr, su, sf;
  } view_rows_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic valid_o;
  logic signed [17:0] right_x_o, right_y_o, right_z_o;
  logic signed [17:0] upward_x_o, upward_y_o, upward_z_o;
  logic signed [17:0] forward_x_o, forward_y_o, forward_z_o;
  logic signed [31:0] shift_right_o, shift_up_o, shift_forward_o;

  view_rows_t pending_rows[$];
  int errors = 0;
  bit gaps_on = 1'b1;

  look_at_view_matrix_top #(.FRAC_BITS(FRAC)) dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic normalize(input longint v[3], output longint u[3]);
    longint unsigned m[3], top, s, len, q;
    int rs, ls;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) m[i] = magnitude(v[i]);
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (top >= (64'd1 << 30)) begin top >>= 1; rs++; end
    while (top < (64'd1 << 29)) begin top <<= 1; ls++; end
    for (int i = 0; i < 3; i++) m[i] = (m[i] >> rs) << ls;
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (FRAC + 1)) + len) / (2 * len);
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic logic [31:0] translation(longint a[3], longint e[3]);
    longint d;
    longint unsigned r;
    d = -(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    r = (magnitude(d) + (64'd1 << (FRAC - 1))) >> FRAC;
    if (d < 0) return r > 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(r));
    return r > 64'h7fff_ffff ? 32'h7fff_ffff : 32'(r);
  endfunction

  task automatic predict_rows(input logic signed [31:0] ex, ey, ez, tx, ty, tz);
    longint eye[3], d[3], fw[3], rt[3], up[3], t[3];
    view_rows_t p;
    eye = '{ex, ey, ez};
    d = '{longint'(tx) - ex, longint'(ty) - ey, longint'(tz) - ez};
    normalize(d, fw);
    t = '{fw[2], 0, -fw[0]};
    normalize(t, rt);
    t = '{fw[1] * rt[2] - fw[2] * rt[1], fw[2] * rt[0] - fw[0] * rt[2],
          fw[0] * rt[1] - fw[1] * rt[0]};
    normalize(t, up);
    p.rx = 18'(rt[0]); p.ry = 18'(rt[1]); p.rz = 18'(rt[2]);
    p.ux = 18'(up[0]); p.uy = 18'(up[1]); p.uz = 18'(up[2]);
    p.fx = 18'(fw[0]); p.fy = 18'(fw[1]); p.fz = 18'(fw[2]);
    p.sr = translation(rt, eye);
    p.su = translation(up, eye);
    p.sf = translation(fw, eye);
    pending_rows.push_back(p);
  endtask

  task automatic send_view(input logic signed [31:0] ex, ey, ez, tx, ty, tz);
    int gap;
    start <= 1'b1;
    eye_x_i <= ex; eye_y_i <= ey; eye_z_i <= ez;
    target_x_i <= tx; target_y_i <= ty; target_z_i <= tz;
    do @(posedge clk_i); while (busy);
    predict_rows(ex, ey, ez, tx, ty, tz);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    view_rows_t got, want;
    if (valid_o) begin
      got = {right_x_o, right_y_o, right_z_o, upward_x_o, upward_y_o, upward_z_o,
             forward_x_o, forward_y_o, forward_z_o,
             shift_right_o, shift_up_o, shift_forward_o};
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h", $time, got);
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'(int'($urandom_range(0, 2000)) - 1000);
      4: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_view(0, 0, 0, 0, 0, 0);
    send_view(32'h1234_5678, -7, 99, 32'h1234_5678, -7, 99);
    send_view(0, 0, 0, 0, 32'h0001_0000, 0);
    send_view(5, 6, 7, 5, -32'h0004_0000, 7);
    send_view(0, 0, 0, 0, 0, 32'h0001_0000);
    send_view(0, 0, 0, 32'h0001_0000, 0, 0);
    send_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_view(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_view(32'h8000_0000, 0, 32'h7fff_ffff, 1, 32'h7fff_ffff, 0);
    send_view(0, 0, 0, 1, 0, 0);
    send_view(0, 0, 0, 1, 1, 1);
    send_view(0, 0, 0, -1, 0, 1);
    send_view(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 0, 0, 0);
    send_view(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 1, 0);
    send_view(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
              32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
  endtask

  task automatic test_random_views;
    logic signed [31:0] ex, ey, ez;
    for (int n = 0; n < 1300; n++) begin
      ex = $urandom; ey = $urandom; ez = $urandom;
      case ($urandom_range(0, 4))
        0: send_view(ex, ey, ez, $urandom, $urandom, $urandom);
        1: send_view(ex >>> 8, ey >>> 8, ez >>> 8, (ex >>> 8) + edge_value(),
                     (ey >>> 8) + (edge_value() >>> 12), (ez >>> 8) + edge_value());
        2: send_view(ex, ey, ez, ex + edge_value(), ey, ez + edge_value());
        3: send_view(edge_value(), edge_value(), edge_value(),
                     edge_value(), edge_value(), edge_value());
        default: send_view(ex >>> 16, ey >>> 16, ez >>> 16, $urandom >>> 20,
                           $urandom >>> 20, $urandom >>> 20);
      endcase
    end
  endtask

  task automatic test_pause_until_empty;
    for (int n = 0; n < 30; n++)
      send_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_back_to_back;
    gaps_on = 1'b0;
    for (int n = 0; n < 300; n++)
      send_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pause_until_empty();
    test_random_views();
    test_back_to_back();
    drain();
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
src/lavm_pkg.sv
src/lavm_norm.sv
src/look_at_view_matrix_top.sv
bench/tb_top.sv
